// File: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

   // Request command codes.
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Character codes with special meaning for a put request, and the blank space.
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   // Reset values of the colour register and of every screen cell.
   localparam logic [7:0]  COLOR_RESET = 8'h0F;
   localparam logic [15:0] CELL_RESET  = 16'h0F20;

   // Width of the position and address fields on the ports.
   localparam int unsigned PORT_POS_W = 11;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_COPY,
      ST_BLANK,
      ST_CLEAR
   } tcw_state_type;

endpackage

`default_nettype wire

// File: rtl/core/text_console_writer_core.sv
// Text console writer: character grid, write position and displayed cursor.
`default_nettype none

// The console holds a COLUMNS x ROWS grid of 16-bit cells (colour byte high,
// character byte low) in a single-port-write, single-port-read memory, and
// a small sequencer drives one address counter over it. After reset the
// block runs a fill pass that writes a white-on-black space into every cell;
// no request is taken during that pass, although colour writes on the csr_
// port are accepted at any time. A put request for newline, carriage return,
// backspace or any other byte, an unused command and a read of an address
// beyond the grid each load their response from the execute state; a read
// inside the grid loads it from the read-wait state, because the memory
// read data is registered. A byte written into the last cell, or a newline
// past column zero on the bottom row, scrolls the grid: the copy loop moves
// one cell per cycle and then blanks the bottom row. A clear request walks
// the whole grid at one cell per cycle. The block works on one request at
// a time; the response sits in an output register, and the next request
// can be accepted in the same cycle as the previous response is taken. The
// row and column of the write position are kept in counters beside the
// linear position, so no division is needed.
module text_console_writer_core #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [10:0] req_cell_address,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [10:0] rsp_write_position,
   output      logic [10:0] rsp_cursor_position,
   output      logic [15:0] rsp_cell_value,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_text_color
);

   import tcw_pkg::*;

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned POS_W = $clog2(CELLS);
   localparam int unsigned COL_W = $clog2(COLUMNS);
   localparam int unsigned ROW_W = $clog2(ROWS);

   localparam logic [COL_W-1:0] COL_LAST       = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST       = ROW_W'(ROWS - 1);
   localparam logic [POS_W-1:0] CELL_LAST      = POS_W'(CELLS - 1);
   localparam logic [POS_W-1:0] BOTTOM_START   = POS_W'(CELLS - COLUMNS);
   localparam logic [POS_W-1:0] COPY_LAST      = POS_W'(CELLS - COLUMNS - 1);
   localparam logic [POS_W-1:0] COLUMNS_POS    = POS_W'(COLUMNS);
   localparam logic [15:0]      CELLS_WIDE     = 16'(CELLS);

   // Sequencer state and the request that is being worked on.
   tcw_state_type    state_ff, state_in;
   logic [1:0]       cmd_ff;
   logic [7:0]       char_ff;
   logic [10:0]      addr_ff;

   // Write position as linear index, column and row, plus the shown cursor.
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0] sweep_ff, sweep_in;
   logic [7:0]       color_ff;

   // Screen memory and its ports.
   logic [15:0]      cells_ff [CELLS];
   logic [15:0]      rd_data_ff;
   logic             mem_we;
   logic [POS_W-1:0] mem_waddr;
   logic [15:0]      mem_wdata;
   logic             mem_re;
   logic [POS_W-1:0] mem_raddr;

   // Response register.
   logic             rsp_valid_ff;
   logic [10:0]      rsp_pos_ff;
   logic [10:0]      rsp_cursor_ff;
   logic [15:0]      rsp_value_ff;
   logic             rsp_load;
   logic [15:0]      rsp_value_in;

   logic             req_accept;
   logic             rsp_taken;
   logic [15:0]      blank_cell;
   logic [15:0]      addr_wide;
   logic [15:0]      pos_wide;
   logic [15:0]      cursor_wide;

   assign blank_cell = {color_ff, CH_SPACE};
   assign addr_wide  = 16'(addr_ff);
   assign pos_wide   = 16'(pos_in);
   assign cursor_wide = 16'(cursor_in);

   // A new request enters only when the sequencer is idle and the response
   // register is empty or is being emptied in this very cycle.
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_write_position  = rsp_pos_ff;
   assign rsp_cursor_position = rsp_cursor_ff;
   assign rsp_cell_value      = rsp_value_ff;

   // The colour register can always be written.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         color_ff <= csr_text_color;
      end
   end

   // Sequencer: state register and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FILL;
         pos_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         cursor_ff <= '0;
         sweep_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         cursor_ff <= cursor_in;
         sweep_ff  <= sweep_in;
      end
   end

   // The request fields are captured when the request is accepted.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_command;
         char_ff <= req_char_code;
         addr_ff <= req_cell_address;
      end
   end

   // Next state, position arithmetic and memory control.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cursor_in    = cursor_ff;
      sweep_in     = sweep_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = blank_cell;
      mem_re       = 1'b0;
      mem_raddr    = sweep_ff;
      rsp_load     = 1'b0;
      rsp_value_in = '0;

      unique case (state_ff)
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = CELL_RESET;
            if (sweep_ff == CELL_LAST) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            case (cmd_ff)
               CMD_PUT: begin
                  case (char_ff)
                     CH_NEWLINE: begin
                        // Newline at column zero leaves the position alone.
                        if (col_ff != '0) begin
                           col_in = '0;
                           if (row_ff == ROW_LAST) begin
                              pos_in    = BOTTOM_START;
                              mem_re    = 1'b1;
                              mem_raddr = COLUMNS_POS;
                              sweep_in  = '0;
                              state_in  = ST_COPY;
                           end else begin
                              row_in = row_ff + 1'b1;
                              pos_in = pos_ff + COLUMNS_POS - POS_W'(col_ff);
                           end
                        end
                     end
                     CH_RETURN: begin
                        pos_in = pos_ff - POS_W'(col_ff);
                        col_in = '0;
                     end
                     CH_BACKSPACE: begin
                        if (pos_ff != '0) begin
                           pos_in    = pos_ff - 1'b1;
                           mem_we    = 1'b1;
                           mem_waddr = pos_ff - 1'b1;
                           if (col_ff == '0) begin
                              col_in = COL_LAST;
                              row_in = row_ff - 1'b1;
                           end else begin
                              col_in = col_ff - 1'b1;
                           end
                        end
                     end
                     default: begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_ff;
                        mem_wdata = {color_ff, char_ff};
                        if (col_ff == COL_LAST) begin
                           col_in = '0;
                           if (row_ff == ROW_LAST) begin
                              pos_in    = BOTTOM_START;
                              cursor_in = BOTTOM_START;
                              mem_re    = 1'b1;
                              mem_raddr = COLUMNS_POS;
                              sweep_in  = '0;
                              state_in  = ST_COPY;
                           end else begin
                              row_in    = row_ff + 1'b1;
                              pos_in    = pos_ff + 1'b1;
                              cursor_in = pos_ff + 1'b1;
                           end
                        end else begin
                           col_in    = col_ff + 1'b1;
                           pos_in    = pos_ff + 1'b1;
                           cursor_in = pos_ff + 1'b1;
                        end
                     end
                  endcase
               end
               CMD_CLEAR: begin
                  pos_in    = '0;
                  col_in    = '0;
                  row_in    = '0;
                  cursor_in = '0;
                  sweep_in  = '0;
                  state_in  = ST_CLEAR;
               end
               CMD_READ: begin
                  if (addr_wide < CELLS_WIDE) begin
                     mem_re    = 1'b1;
                     mem_raddr = addr_wide[POS_W-1:0];
                     state_in  = ST_READ_WAIT;
                  end
               end
               default: begin
               end
            endcase
            rsp_load = (state_in == ST_IDLE);
         end

         ST_READ_WAIT: begin
            rsp_load     = 1'b1;
            rsp_value_in = rd_data_ff;
            state_in     = ST_IDLE;
         end

         ST_COPY: begin
            // Write the cell read in the previous cycle one row higher and
            // fetch the next one.
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = rd_data_ff;
            if (sweep_ff == COPY_LAST) begin
               sweep_in = BOTTOM_START;
               state_in = ST_BLANK;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = sweep_ff + COLUMNS_POS + 1'b1;
               sweep_in  = sweep_ff + 1'b1;
            end
         end

         ST_BLANK, ST_CLEAR: begin
            mem_we = 1'b1;
            if (sweep_ff == CELL_LAST) begin
               sweep_in = '0;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Screen memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= cells_ff[mem_raddr];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pos_ff    <= pos_wide[PORT_POS_W-1:0];
         rsp_cursor_ff <= cursor_wide[PORT_POS_W-1:0];
         rsp_value_ff  <= rsp_value_in;
      end
   end

   // The position counters always describe a cell inside the grid.
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= CELL_LAST) && (cursor_ff <= CELL_LAST))
      else $error("write position or cursor outside the grid");

   // Linear position, row and column must agree.
   a_pos_consistent: assert property (@(posedge clock) disable iff (reset)
      (int'(pos_ff) == int'(row_ff) * COLUMNS + int'(col_ff))
      && (col_ff <= COL_LAST) && (row_ff <= ROW_LAST))
      else $error("position does not match row and column");

   // While a request is in progress the response register is empty.
   a_rsp_empty_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a request is in progress");

   // A response is loaded only when the register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff)
      else $error("response register overwritten");

endmodule

`default_nettype wire
